FILE: hw/rtl/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_NOW(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ant, con) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
        else $error("assertion failed");

`endif

FILE: hw/rtl/girc_pkg.sv
// package for the gene interval read counter
// types, codes and constants; no dependencies
package girc_pkg;

    localparam int MAX_GENES_DEF  = 8192;
    localparam int COORD_BITS_DEF = 32;
    localparam int RPKM_W         = 40;
    localparam int K_ODD          = 1953125;  // 10^9 * 2^8 = 5^9 * 2^17
    localparam int K_SHIFT        = 17;
    localparam int K_ODD_W        = 21;

    typedef enum logic [1:0] {
        CMD_LOAD  = 2'd0,
        CMD_COUNT = 2'd1,
        CMD_READ  = 2'd2,
        CMD_NONE  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_FULL  = 3'd1,
        ST_BADIX = 3'd2,
        ST_ORDER = 3'd3,
        ST_UNDEF = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SRD,
        S_SCMP,
        S_FCHK,
        S_RDAT,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_DEN,
        S_DCHK,
        S_DIV
    } t_state;

    function automatic logic [31:0] sat_inc(input logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

endpackage

FILE: hw/rtl/gene_interval_read_counter_unit.sv
// gene interval read counter: interval table, binary search, per-gene counts, rpkm
// depends on girc_pkg and assert_macros.svh
//
// channel   handshake          payload
// input     start & !busy      i_command i_position i_end_position i_gene_index
// result    o_valid, 1 cycle   o_status o_matched o_hit_index o_read_count
//                              o_gene_length o_rpkm_fixed o_unquantified_total
//                              o_counted_total
//
// load, bad index and unused command: result in the next cycle, busy stays low
// count: binary search on interval starts, SRD and SCMP per step, then end check in FCHK
// readout: RDAT, then if defined MUL1-MUL3, DEN, DCHK (ends if saturated), restoring divider
// reset is synchronous; no clearing pass, a load writes the new entry's count to zero
// the receiver cannot stall; busy holds off new transactions
`include "assert_macros.svh"

module gene_interval_read_counter_unit #(
    parameter int MAX_GENES  = girc_pkg::MAX_GENES_DEF,
    parameter int COORD_BITS = girc_pkg::COORD_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_command,
    input  logic [31:0] i_position,
    input  logic [31:0] i_end_position,
    input  logic [12:0] i_gene_index,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic        o_matched,
    output logic [12:0] o_hit_index,
    output logic [31:0] o_read_count,
    output logic [31:0] o_gene_length,
    output logic [39:0] o_rpkm_fixed,
    output logic [31:0] o_unquantified_total,
    output logic [31:0] o_counted_total
);
    import girc_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int IW = $clog2(MAX_GENES);
    localparam int NW = $clog2(MAX_GENES + 1);
    localparam int LW = CW + 32;
    localparam int DW = 32 + CW + RPKM_W;
    localparam int PW = 32 + K_ODD_W;

    t_state r_state, n_state;

    logic [NW-1:0]     r_loaded, n_loaded;
    logic [CW-1:0]     r_last, n_last;
    logic [31:0]       r_assigned, n_assigned, r_orphan, n_orphan;
    logic [NW-1:0]     r_lo, n_lo, r_hi, n_hi;
    logic [CW-1:0]     r_pos, n_pos;
    logic [CW-1:0]     r_glen, n_glen;
    logic [63:0]       r_p0, n_p0, r_p1, n_p1;
    logic [DW-1:0]     r_num, n_num, r_dsh, n_dsh;
    logic [RPKM_W-1:0] r_q, n_q;
    logic [5:0]        r_step, n_step;

    logic              r_valid, n_valid;
    t_status           r_status, n_status;
    logic              r_matched, n_matched;
    logic [IW-1:0]     r_hit, n_hit;
    logic [31:0]       r_count, n_count;
    logic [31:0]       r_len, n_len;
    logic [RPKM_W-1:0] r_rpkm, n_rpkm;

    logic [2*CW-1:0] r_iv_mem [MAX_GENES];
    logic [31:0]     r_cnt_mem [MAX_GENES];
    logic [2*CW-1:0] r_iv_rd;
    logic [31:0]     r_cnt_rd;

    logic            w_accept;
    logic [CW-1:0]   w_ipos, w_iend, w_rstart, w_rend, w_len;
    logic [NW-1:0]   w_mid;
    logic [IW-1:0]   w_rd_addr, w_wr_addr;
    logic            w_iv_we, w_cnt_we;
    logic [31:0]     w_cnt_wd, w_inc;
    logic            w_idx_ok;
    logic [LW-1:0]   w_lx;
    logic [63:0]     w_len64;
    logic [PW-1:0]   w_prod;
    logic            w_qbit;

    assign w_accept  = start && !busy;
    assign w_ipos    = CW'(i_position);
    assign w_iend    = CW'(i_end_position);
    assign w_rstart  = r_iv_rd[CW-1:0];
    assign w_rend    = r_iv_rd[2*CW-1:CW];
    assign w_mid     = r_lo + ((r_hi - r_lo) >> 1);
    assign w_idx_ok  = 32'(i_gene_index) < 32'(r_loaded);
    assign w_len     = (w_rend >= w_rstart) ? w_rend - w_rstart : '0;
    assign w_inc     = sat_inc(r_cnt_rd);
    assign w_len64   = 64'(r_glen);
    assign w_prod    = PW'(r_count) * PW'(K_ODD);
    assign w_qbit    = r_num >= r_dsh;

    always_comb begin
        unique case (r_state)
            S_IDLE:  w_rd_addr = IW'(i_gene_index);
            S_SRD:   w_rd_addr = (r_lo < r_hi) ? w_mid[IW-1:0] : IW'(r_lo - NW'(1));
            default: w_rd_addr = w_mid[IW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_iv_we) begin
            r_iv_mem[w_wr_addr] <= {w_iend, w_ipos};
        end
        r_iv_rd <= r_iv_mem[w_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_cnt_we) begin
            r_cnt_mem[w_wr_addr] <= w_cnt_wd;
        end
        r_cnt_rd <= r_cnt_mem[w_rd_addr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (t_cmd'(i_command) == CMD_COUNT) begin
                        n_state = S_SRD;
                    end else if (t_cmd'(i_command) == CMD_READ && w_idx_ok) begin
                        n_state = S_RDAT;
                    end
                end
            end
            S_SRD: begin
                if (r_lo < r_hi) begin
                    n_state = S_SCMP;
                end else if (r_lo == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_FCHK;
                end
            end
            S_SCMP:  n_state = S_SRD;
            S_FCHK:  n_state = S_IDLE;
            S_RDAT:  n_state = (r_assigned == '0 || w_len == '0) ? S_IDLE : S_MUL1;
            S_MUL1:  n_state = S_MUL2;
            S_MUL2:  n_state = S_MUL3;
            S_MUL3:  n_state = S_DEN;
            S_DEN:   n_state = S_DCHK;
            S_DCHK:  n_state = w_qbit ? S_IDLE : S_DIV;
            S_DIV:   n_state = (r_step == '0) ? S_IDLE : S_DIV;
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and results
    always_comb begin
        n_loaded   = r_loaded;
        n_last     = r_last;
        n_assigned = r_assigned;
        n_orphan   = r_orphan;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_pos      = r_pos;
        n_glen     = r_glen;
        n_p0       = r_p0;
        n_p1       = r_p1;
        n_num      = r_num;
        n_dsh      = r_dsh;
        n_q        = r_q;
        n_step     = r_step;
        n_valid    = 1'b0;
        n_status   = r_status;
        n_matched  = r_matched;
        n_hit      = r_hit;
        n_count    = r_count;
        n_len      = r_len;
        n_rpkm     = r_rpkm;
        w_iv_we    = 1'b0;
        w_cnt_we   = 1'b0;
        w_wr_addr  = r_hit;
        w_cnt_wd   = '0;
        w_lx       = LW'(w_len);
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_status  = ST_OK;
                    n_matched = 1'b0;
                    n_hit     = '0;
                    n_count   = '0;
                    n_len     = '0;
                    n_rpkm    = '0;
                    unique case (t_cmd'(i_command))
                        CMD_LOAD: begin
                            n_valid = 1'b1;
                            if (32'(r_loaded) >= 32'(MAX_GENES)) begin
                                n_status = ST_FULL;
                            end else if (r_loaded != '0 && w_ipos < r_last) begin
                                n_status = ST_ORDER;
                            end else begin
                                w_wr_addr = IW'(r_loaded);
                                w_iv_we   = 1'b1;
                                w_cnt_we  = 1'b1;
                                n_loaded  = r_loaded + NW'(1);
                                n_last    = w_ipos;
                                n_hit     = IW'(r_loaded);
                                w_lx      = LW'((w_iend >= w_ipos) ? w_iend - w_ipos : '0);
                                n_len     = (|w_lx[LW-1:32]) ? '1 : w_lx[31:0];
                            end
                        end
                        CMD_COUNT: begin
                            n_lo  = '0;
                            n_hi  = r_loaded;
                            n_pos = w_ipos;
                        end
                        CMD_READ: begin
                            n_hit = IW'(i_gene_index);
                            if (!w_idx_ok) begin
                                n_valid  = 1'b1;
                                n_status = ST_BADIX;
                            end
                        end
                        default: n_valid = 1'b1;
                    endcase
                end
            end
            S_SRD: begin
                if (r_lo >= r_hi) begin
                    if (r_lo == '0) begin
                        n_valid  = 1'b1;
                        n_orphan = sat_inc(r_orphan);
                    end else begin
                        n_hit = IW'(r_lo - NW'(1));
                    end
                end
            end
            S_SCMP: begin
                if (w_rstart <= r_pos) begin
                    n_lo = w_mid + NW'(1);
                end else begin
                    n_hi = w_mid;
                end
            end
            S_FCHK: begin
                n_valid = 1'b1;
                if (r_pos <= w_rend) begin
                    w_cnt_we   = 1'b1;
                    w_cnt_wd   = w_inc;
                    n_assigned = sat_inc(r_assigned);
                    n_matched  = 1'b1;
                    n_count    = w_inc;
                end else begin
                    n_orphan = sat_inc(r_orphan);
                    n_count  = r_cnt_rd;
                end
            end
            S_RDAT: begin
                n_glen  = w_len;
                n_count = r_cnt_rd;
                n_len   = (|w_lx[LW-1:32]) ? '1 : w_lx[31:0];
                if (r_assigned == '0 || w_len == '0) begin
                    n_valid  = 1'b1;
                    n_status = ST_UNDEF;
                end
            end
            S_MUL1: n_num = DW'(w_prod) << K_SHIFT;
            S_MUL2: n_p0  = 64'(r_assigned) * 64'(w_len64[31:0]);
            S_MUL3: n_p1  = 64'(r_assigned) * 64'(w_len64[63:32]);
            S_DEN:  n_dsh = (DW'(r_p0) + (DW'(r_p1) << 32)) << RPKM_W;
            S_DCHK: begin
                if (w_qbit) begin
                    n_valid = 1'b1;
                    n_rpkm  = '1;
                end else begin
                    n_dsh  = r_dsh >> 1;
                    n_step = 6'(RPKM_W - 1);
                    n_q    = '0;
                end
            end
            S_DIV: begin
                if (w_qbit) begin
                    n_num = r_num - r_dsh;
                end
                n_q    = {r_q[RPKM_W-2:0], w_qbit};
                n_dsh  = r_dsh >> 1;
                n_step = r_step - 6'd1;
                if (r_step == '0) begin
                    n_valid = 1'b1;
                    n_rpkm  = {r_q[RPKM_W-2:0], w_qbit};
                end
            end
            default: n_valid = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_loaded   <= '0;
            r_assigned <= '0;
            r_orphan   <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_loaded   <= n_loaded;
            r_assigned <= n_assigned;
            r_orphan   <= n_orphan;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last    <= n_last;
        r_lo      <= n_lo;
        r_hi      <= n_hi;
        r_pos     <= n_pos;
        r_glen    <= n_glen;
        r_p0      <= n_p0;
        r_p1      <= n_p1;
        r_num     <= n_num;
        r_dsh     <= n_dsh;
        r_q       <= n_q;
        r_step    <= n_step;
        r_status  <= n_status;
        r_matched <= n_matched;
        r_hit     <= n_hit;
        r_count   <= n_count;
        r_len     <= n_len;
        r_rpkm    <= n_rpkm;
    end

    // outputs
    always_comb begin
        busy                 = (r_state != S_IDLE);
        o_valid              = r_valid;
        o_status             = r_status;
        o_matched            = r_matched;
        o_hit_index          = 13'(r_hit);
        o_read_count         = r_count;
        o_gene_length        = r_len;
        o_rpkm_fixed         = r_rpkm;
        o_unquantified_total = r_orphan;
        o_counted_total      = r_assigned;
    end

    `ASSERT_NOW(a_fill_bound, i_clk, i_rst_n, 1'b1, 32'(r_loaded) <= 32'(MAX_GENES))
    `ASSERT_NEXT(a_count_busy, i_clk, i_rst_n, w_accept && i_command == CMD_COUNT, busy)
    `ASSERT_NOW(a_search_order, i_clk, i_rst_n, r_state == S_SCMP, r_lo < r_hi)
    `ASSERT_NOW(a_match_ok, i_clk, i_rst_n, r_valid && r_matched, r_status == ST_OK)

endmodule
